/* rtl/swts_pkg.sv */
// Package for the sliding window trend statistics block.
// Holds widths, limits and the sequencer state type; no dependencies.
package swts_pkg;
  localparam int WindowMaxDef = 64;
  localparam int SampleW      = 8;
  localparam int CountW       = 7;
  localparam int CfgReset     = 10;
  localparam int PredHorizon  = 60;
  localparam int PredMax      = 110;
  localparam int SlopeMin     = -65536;
  localparam int SlopeMax     = 65535;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MULD,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage

/* rtl/sliding_window_trend_stats_top.sv */
// Sliding window trend statistics: one sample in, one result out.
// After each input transfer it walks the n stored samples, does a setup step, then runs
// three serial divisions (average, slope, prediction) and outputs; n is the fill count after the push.
// Input is accepted only while idle and no result is held, so a sample waits while a result is held.
// Synchronous active-low reset clears head, count and control state and sets the window length
// to CfgReset; the sample memory is not cleared.
module sliding_window_trend_stats_top #(
  parameter int WINDOW_MAX = swts_pkg::WindowMaxDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample_temp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_fill_count,
  output logic        out_stats_valid,
  output logic [15:0] out_avg_q8,
  output logic [7:0]  out_min_temp,
  output logic [7:0]  out_max_temp,
  output logic signed [16:0] out_slope_q8,
  output logic [15:0] out_pred_q8,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int DW = 64;
  localparam int DCW = 7;

  localparam logic [1:0] DIV_AVG    = 2'd0;
  localparam logic [1:0] DIV_SLOPE  = 2'd1;
  localparam logic [1:0] DIV_PRED   = 2'd2;
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  logic [7:0] mem [WINDOW_MAX];
  logic [7:0] rd_data_r;

  swts_pkg::state_t state_r, state_nxt;
  logic [6:0]  wlen_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] n_r;
  logic [AW-1:0] rd_addr_r;
  logic [NW:0]   idx_r;      // read issue index
  logic [NW:0]   acc_i_r;    // accumulate index (one behind)
  logic          acc_en_r;
  logic [7:0]    last_r, mn_r, mx_r;
  logic [23:0]   sum_r;
  logic signed [31:0] t_r;
  logic signed [DW-1:0] d_r;
  logic [2*NW-1:0] nsq_r;
  logic [3*NW-1:0] dpoly_r;  // n*(n*n-1)
  logic [1:0]    div_sel_r;
  logic [DW-1:0] quo_r, rem_r, dnum_r;
  logic [DCW-1:0] dcnt_r;
  logic          dneg_r;
  logic [15:0]   avg_r, pred_r;
  logic signed [16:0] slope_r;
  logic [1:0]    pclamp_r;
  logic signed [DW-1:0] pnum_r;

  logic [NW-1:0] eff;
  always_comb begin
    if (wlen_r < 7'd2) eff = NW'(2);
    else if (32'(wlen_r) > WINDOW_MAX) eff = NW'(WINDOW_MAX);
    else eff = NW'(wlen_r);
  end

  logic in_xfer;
  assign in_ready = (state_r == swts_pkg::ST_IDLE) && !out_valid;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer) mem[head_r] <= in_sample_temp;
    rd_data_r <= mem[rd_addr_r];
  end

  // division: numerator magnitude dnum_r over 2*d (divisor 2d, numerator 2|x|+d)
  logic [DW-1:0] den2, rem_sh, rem_try;
  assign den2    = DW'(d_r) << 1;
  assign rem_sh  = {rem_r[DW-2:0], dnum_r[DW-1]};
  assign rem_try = rem_sh - den2;

  logic signed [DW-1:0] tq;   // t*6*256
  logic signed [DW-1:0] tp;   // 60*6*256*t
  assign tq = DW'(t_r) * 64'sd1536;
  assign tp = DW'(t_r) * 64'sd92160;

  logic [3*NW+7:0] lastd;
  assign lastd = (3*NW+8)'(last_r) * (3*NW+8)'(dpoly_r);

  logic signed [DW-1:0] qs;
  assign qs = dneg_r ? -$signed(quo_r) : $signed(quo_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    unique case (state_r)
      swts_pkg::ST_IDLE: if (in_xfer) begin
        state_nxt = swts_pkg::ST_WALK;
        head_nxt  = (32'(head_r) == WINDOW_MAX - 1) ? '0 : head_r + AW'(1);
        count_nxt = ((NW+1)'(count_r) + (NW+1)'(1) > (NW+1)'(eff)) ? eff
                                                                    : count_r + NW'(1);
      end
      swts_pkg::ST_WALK: if (acc_en_r && acc_i_r == (NW+1)'(n_r) - 1'b1 && idx_r >= (NW+1)'(n_r))
        state_nxt = swts_pkg::ST_MULD;
      swts_pkg::ST_MULD: state_nxt = swts_pkg::ST_DIV;
      swts_pkg::ST_DIV: if (dcnt_r == '0 && div_sel_r == DIV_PRED) state_nxt = swts_pkg::ST_OUT;
      swts_pkg::ST_OUT: state_nxt = swts_pkg::ST_IDLE;
      default: state_nxt = swts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swts_pkg::ST_IDLE;
      wlen_r  <= 7'(swts_pkg::CfgReset);
      head_r  <= '0;
      count_r <= '0;
      out_valid <= 1'b0;
      acc_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_we) wlen_r <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state_r == swts_pkg::ST_OUT) out_valid <= 1'b1;
      acc_en_r <= (state_r == swts_pkg::ST_WALK) && (idx_r < (NW+1)'(n_r));
    end
  end

  logic [AW:0] start_w;
  assign start_w = (AW+1)'(head_nxt) + (AW+1)'(WINDOW_MAX) - (AW+1)'(count_nxt);

  always_ff @(posedge clk) begin
    unique case (state_r)
      // hold the finished result until the next transfer
      swts_pkg::ST_IDLE: if (in_xfer) begin
        n_r    <= count_nxt;
        last_r <= in_sample_temp;
        rd_addr_r <= (32'(start_w) >= WINDOW_MAX) ? AW'(start_w - (AW+1)'(WINDOW_MAX))
                                                 : AW'(start_w);
        idx_r  <= '0;
        acc_i_r <= '0;
        mn_r <= 8'hff; mx_r <= 8'h00; sum_r <= '0; t_r <= '0;
      end
      swts_pkg::ST_WALK: begin
        if (idx_r < (NW+1)'(n_r)) begin
          idx_r <= idx_r + 1'b1;
          rd_addr_r <= (32'(rd_addr_r) == WINDOW_MAX - 1) ? '0 : rd_addr_r + AW'(1);
        end
        if (acc_en_r) begin
          if (rd_data_r < mn_r) mn_r <= rd_data_r;
          if (rd_data_r > mx_r) mx_r <= rd_data_r;
          sum_r <= sum_r + 24'(rd_data_r);
          t_r <= t_r + (32'(acc_i_r) * 2 - 32'(n_r) + 1) * $signed({24'd0, rd_data_r});
          acc_i_r <= acc_i_r + 1'b1;
        end
        // n*(n*n-1) settles during the walk, through nsq_r and then dpoly_r
        nsq_r   <= (2*NW)'(n_r) * (2*NW)'(n_r);
        dpoly_r <= (3*NW)'(n_r) * (3*NW)'(nsq_r - 1'b1);
        // first division: average, divisor n
        d_r <= DW'(n_r);
        dnum_r <= DW'({sum_r, 8'd0}) * 2;
      end
      swts_pkg::ST_MULD: begin
        dnum_r <= DW'({sum_r, 9'd0}) + DW'(n_r);
        quo_r <= '0; rem_r <= '0; dcnt_r <= DCW'(DW); dneg_r <= 1'b0;
        div_sel_r <= DIV_AVG;
        pnum_r <= $signed(DW'({lastd, 8'd0})) + tp;
      end
      swts_pkg::ST_DIV: begin
        if (dcnt_r != '0) begin
          dnum_r <= dnum_r << 1;
          if (!rem_try[DW-1]) begin
            rem_r <= rem_try; quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;  quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
        end else begin
          unique case (div_sel_r)
            DIV_AVG: begin
              avg_r <= quo_r[15:0];
              d_r <= DW'(dpoly_r);
              div_sel_r <= DIV_SLOPE;
              dneg_r <= tq[DW-1];
              dnum_r <= 2 * DW'(tq[DW-1] ? -tq : tq) + DW'(dpoly_r);
              quo_r <= '0; rem_r <= '0; dcnt_r <= DCW'(DW);
            end
            DIV_SLOPE: begin
              if (qs < 64'(swts_pkg::SlopeMin)) slope_r <= 17'(swts_pkg::SlopeMin);
              else if (qs > 64'(swts_pkg::SlopeMax)) slope_r <= 17'(swts_pkg::SlopeMax);
              else slope_r <= qs[16:0];
              div_sel_r <= DIV_PRED;
              dneg_r <= 1'b0;
              if (pnum_r < 0) pclamp_r <= CLAMP_LOW;
              else if (pnum_r > 64'sd28160 * d_r) pclamp_r <= CLAMP_HIGH;
              else pclamp_r <= CLAMP_NONE;
              dnum_r <= 2 * DW'(pnum_r < 0 ? 64'sd0 : pnum_r) + DW'(d_r);
              quo_r <= '0; rem_r <= '0; dcnt_r <= DCW'(DW);
            end
            default: begin
              if (n_r < NW'(2)) pred_r <= {last_r, 8'd0};
              else if (pclamp_r == CLAMP_LOW) pred_r <= '0;
              else if (pclamp_r == CLAMP_HIGH) pred_r <= 16'(swts_pkg::PredMax * 256);
              else pred_r <= quo_r[15:0];
              if (n_r < NW'(2)) slope_r <= '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_fill_count  = 7'(n_r);
  assign out_stats_valid = (n_r >= NW'(2));
  assign out_avg_q8      = avg_r;
  assign out_min_temp    = mn_r;
  assign out_max_temp    = mx_r;
  assign out_slope_q8    = slope_r;
  assign out_pred_q8     = pred_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != swts_pkg::ST_IDLE |-> !in_ready) else $error("accept while busy");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_count >= 7'd1 && 32'(out_fill_count) <= WINDOW_MAX))
    else $error("fill count out of range");
  a_pred_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stats_valid) |-> out_pred_q8 <= 16'd28160) else $error("pred clamp");
endmodule

/* test/sliding_window_trend_stats_top_tb.sv */
// Testbench for sliding_window_trend_stats_top: random and directed samples with
// a scoreboard that predicts window statistics. Depends on swts_pkg and the RTL.
`timescale 1ns / 100ps

class trend_scoreboard;
  typedef struct packed {
    bit [6:0]  fill;
    bit        sv;
    bit [15:0] avg;
    bit [7:0]  mn;
    bit [7:0]  mx;
    bit [16:0] slope;
    bit [15:0] pred;
  } exp_t;

  bit [7:0]  ring [64];
  int        head;
  int        count;
  bit [6:0]  win_len;
  int        errors;
  exp_t      exp_q [$];

  function new();
    head = 0;
    count = 0;
    win_len = 7'(swts_pkg::CfgReset);
    errors = 0;
  endfunction

  function longint round_div(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function int pending();
    return exp_q.size();
  endfunction

  function void note_sample(bit [7:0] temp);
    int eff, n, start;
    bit [7:0] y, mn, mx;
    longint sum, t, d, num, slope, pred;
    exp_t e;
    eff = win_len;
    if (eff < 2) eff = 2;
    if (eff > swts_pkg::WindowMaxDef) eff = swts_pkg::WindowMaxDef;
    ring[head] = temp;
    head = (head + 1) % 64;
    n = count + 1;
    if (n > eff) n = eff;
    count = n;
    start = (head + 64 - n) % 64;
    mn = 255;
    mx = 0;
    sum = 0;
    t = 0;
    for (int i = 0; i < n; i++) begin
      y = ring[(start + i) % 64];
      if (y < mn) mn = y;
      if (y > mx) mx = y;
      sum += y;
      t += (2 * i - n + 1) * longint'(y);
    end
    if (n >= 2) begin
      d = longint'(n) * (longint'(n) * n - 1);
      slope = round_div(t * 6 * 256, d);
      if (slope < swts_pkg::SlopeMin) slope = swts_pkg::SlopeMin;
      if (slope > swts_pkg::SlopeMax) slope = swts_pkg::SlopeMax;
      num = longint'(temp) * 256 * d + longint'(swts_pkg::PredHorizon) * 6 * 256 * t;
      if (num < 0) pred = 0;
      else if (num > longint'(swts_pkg::PredMax) * 256 * d) pred = swts_pkg::PredMax * 256;
      else pred = round_div(num, d);
    end else begin
      slope = 0;
      pred = longint'(temp) * 256;
    end
    e.fill  = 7'(n);
    e.sv    = (n >= 2);
    e.avg   = 16'(round_div(sum * 256, n));
    e.mn    = mn;
    e.mx    = mx;
    e.slope = 17'(slope);
    e.pred  = 16'(pred);
    exp_q = {exp_q, e};
  endfunction

  function void check_result(bit [6:0] fill, bit sv, bit [15:0] avg, bit [7:0] mn,
                             bit [7:0] mx, bit [16:0] slope, bit [15:0] pred);
    exp_t e;
    if (exp_q.size() == 0) begin
      $error("unexpected result transfer");
      errors++;
      return;
    end
    e = exp_q[0];
    exp_q.delete(0);
    if (fill !== e.fill) begin
      $error("fill_count expected %0d actual %0d", e.fill, fill); errors++;
    end
    if (sv !== e.sv) begin
      $error("stats_valid expected %0d actual %0d", e.sv, sv); errors++;
    end
    if (avg !== e.avg) begin
      $error("avg_q8 expected %0d actual %0d", e.avg, avg); errors++;
    end
    if (mn !== e.mn) begin
      $error("min_temp expected %0d actual %0d", e.mn, mn); errors++;
    end
    if (mx !== e.mx) begin
      $error("max_temp expected %0d actual %0d", e.mx, mx); errors++;
    end
    if (slope !== e.slope) begin
      $error("slope_q8 expected %h actual %h", e.slope, slope); errors++;
    end
    if (pred !== e.pred) begin
      $error("pred_q8 expected %0d actual %0d", e.pred, pred); errors++;
    end
  endfunction
endclass

module sliding_window_trend_stats_top_tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_sample_temp;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_fill_count;
  logic        out_stats_valid;
  logic [15:0] out_avg_q8;
  logic [7:0]  out_min_temp;
  logic [7:0]  out_max_temp;
  logic signed [16:0] out_slope_q8;
  logic [15:0] out_pred_q8;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  trend_scoreboard sb;
  bit rx_hold;
  bit stim_done;

  sliding_window_trend_stats_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_temp(in_sample_temp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fill_count(out_fill_count), .out_stats_valid(out_stats_valid),
    .out_avg_q8(out_avg_q8), .out_min_temp(out_min_temp), .out_max_temp(out_max_temp),
    .out_slope_q8(out_slope_q8), .out_pred_q8(out_pred_q8),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Drive one sample; drop valid for the gap, then hold it until the transfer.
  // Valid stays high after the transfer until the next sample or a drain.
  task automatic send_sample(bit [7:0] temp, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_sample_temp <= temp;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(temp);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_window(bit [6:0] len);
    wait_drained();
    cfg_we <= 1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 0;
    sb.win_len = len;
  endtask

  // Mostly ramps and plateaus so slope and clamping see real trends.
  function automatic bit [7:0] next_temp(int mode, int k, bit [7:0] base);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return 8'(base + k);
      2: return 8'(base - k);
      3: return 8'(base + $urandom_range(0, 3));
      default: return (k % 2) ? 8'd255 : 8'd0;
    endcase
  endfunction

  initial begin
    int gap;
    @(negedge clk);
    while (!stim_done || sb.pending() != 0 || out_valid) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (rx_hold) begin
        out_ready <= 0;
        repeat (2000) @(negedge clk);
        rx_hold = 0;
      end
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid)
        sb.check_result(out_fill_count, out_stats_valid, out_avg_q8, out_min_temp,
                        out_max_temp, out_slope_q8, out_pred_q8);
      @(negedge clk);
    end
    out_ready <= 0;
  end

  initial begin
    bit [6:0] lens [8] = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd5, 7'd33};
    bit [7:0] base;
    int mode, run;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_sample_temp = 0;
    out_ready = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    rx_hold = 0;
    stim_done = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Single sample, then extremes and a steep rise to saturate the prediction.
    send_sample(8'd200);
    send_sample(8'd0);
    send_sample(8'd255);
    for (int i = 0; i < 8; i++) send_sample(8'(i * 36));
    write_window(7'd2);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    write_window(7'd64);
    for (int i = 0; i < 6; i++) send_sample(8'(255 - i * 40));
    // Shorten the window after filling it.
    write_window(7'd3);
    send_sample(8'd17);
    send_sample(8'd18);
    // Stall the receiver while the sender keeps offering.
    rx_hold = 1;
    for (int i = 0; i < 6; i++) send_sample(8'($urandom_range(0, 255)), 1);
    for (int p = 0; p < 16; p++) begin
      if (p % 2 == 0) write_window(lens[(p / 2) % 8]);
      else write_window(7'($urandom_range(0, 127)));
      run = 0;
      while (run < 125) begin
        mode = $urandom_range(0, 4);
        base = 8'($urandom_range(0, 255));
        for (int k = 0; k < 10 && run < 125; k++, run++)
          send_sample(next_temp(mode, k, base));
      end
      if (p == 7) wait_drained();
    end
    write_window(7'd10);
    send_sample(8'd50);
    wait_drained();
    stim_done = 1;
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("sliding_window_trend_stats_top regression: pass");
    else
      $display("sliding_window_trend_stats_top regression: fail");
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("sliding_window_trend_stats_top regression: fail");
    $finish;
  end
endmodule

/* sliding_window_trend_stats_top.f */
rtl/swts_pkg.sv
rtl/sliding_window_trend_stats_top.sv
test/sliding_window_trend_stats_top_tb.sv
